### rtl/slcan_pkg.sv
// Shared types, character constants and helper functions for the SLCAN frame encoder.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package slcan_pkg;

    // Item kinds on the input side
    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_DATA   = 1'b1;

    // Classic frame kinds
    localparam logic [1:0] FRAME_KIND_DATA   = 2'd0;
    localparam logic [1:0] FRAME_KIND_REMOTE = 2'd1;
    localparam logic [1:0] FRAME_KIND_OTHER  = 2'd2;

    // ASCII characters used on the SLCAN line
    localparam logic [7:0] CHAR_T_DATA   = 8'h74;  // 't'
    localparam logic [7:0] CHAR_R_REMOTE = 8'h72;  // 'r'
    localparam logic [7:0] CHAR_U_OTHER  = 8'h75;  // 'u'
    localparam logic [7:0] CHAR_B_FD_BRS = 8'h62;  // 'b'
    localparam logic [7:0] CHAR_D_FD     = 8'h64;  // 'd'
    localparam logic [7:0] CHAR_CASE_GAP = 8'h20;  // lower to upper case offset
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_HEX_A    = 8'h41;

    // Identifier digit counts
    localparam logic [3:0] STD_ID_DIGITS = 4'd3;
    localparam logic [3:0] EXT_ID_DIGITS = 4'd8;

    // Job queue between front and back
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    typedef struct packed {
        logic        ok;
        logic [3:0]  code;
    } len_code_t;

    // One unit of work for the back part: a frame header or one data byte
    typedef struct packed {
        logic        is_header;
        logic [7:0]  letter;
        logic [28:0] ident;      // already masked to 11 bits for standard ids
        logic [3:0]  num_digits; // identifier digits
        logic [3:0]  len_code;
        logic [7:0]  data_byte;
        logic [3:0]  last_idx;   // index of the final character of this job
        logic        err_flag;   // sticky length error as seen by this job
    } job_t;

    // Map a 4-bit value to an upper-case hex character
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'hA)
            r = CHAR_ZERO + {4'h0, v};
        else
            r = CHAR_HEX_A + {4'h0, v - 4'hA};
        return r;
    endfunction

    // FD byte count to DLC code
    function automatic len_code_t fd_len_code(input logic [6:0] count);
        len_code_t r;
        r.ok   = 1'b1;
        r.code = 4'd0;
        unique case (count)
            7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8:
                r.code = count[3:0];
            7'd12: r.code = 4'd9;
            7'd16: r.code = 4'd10;
            7'd20: r.code = 4'd11;
            7'd24: r.code = 4'd12;
            7'd32: r.code = 4'd13;
            7'd48: r.code = 4'd14;
            7'd64: r.code = 4'd15;
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### rtl/slcan_frame_text_encoder.sv
// SLCAN frame text encoder, top level: front part, job queue and back part.
// The first character of an item goes through the job queue, then the output register.
// Throughput: one character per cycle while results are popped; a data byte gives 2 or 3
// characters and a header 5 to 11, emitted by the back part into the output register.
// Input transfers continue while the back part works until the two-entry job queue fills.
// Reset (rst_n low, asynchronous): frame state, sticky error, queue and output clear.
module slcan_frame_text_encoder #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input side
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic        is_fd,
    input  logic        bit_rate_switch,
    input  logic [1:0]  frame_kind,
    input  logic        extended_id,
    input  logic [28:0] identifier,
    input  logic [6:0]  byte_count,
    input  logic [7:0]  payload_byte,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  char_code,
    output logic        end_of_line,
    output logic        length_error_seen
);

    // Jobs handed from front to back
    slcan_pkg::job_t front_job;
    slcan_pkg::job_t head_job;
    logic            front_job_valid;
    logic            q_empty;
    logic            q_full;
    logic            q_pop;

    // Hold off new items while the job queue is full, including items that yield
    // no characters (bad lengths, dropped or stray bytes).
    assign full = q_full;

    // Front: classify each transfer, update frame state, issue one job per
    // header or data byte that produces text.
    slcan_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .q_full          (q_full),
        .mode            (mode),
        .is_fd           (is_fd),
        .bit_rate_switch (bit_rate_switch),
        .frame_kind      (frame_kind),
        .extended_id     (extended_id),
        .identifier      (identifier),
        .byte_count      (byte_count),
        .payload_byte    (payload_byte),
        .job_valid       (front_job_valid),
        .job             (front_job)
    );

    // Decouple the two sides so the front keeps taking items during long headers
    slcan_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_job_valid),
        .wr_job  (front_job),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    // Back: walk the head job character by character; advance into the output
    // register whenever it is free or being transferred out this cycle.
    slcan_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .head_job          (head_job),
        .q_pop             (q_pop),
        .pop               (pop),
        .empty             (empty),
        .char_code         (char_code),
        .end_of_line       (end_of_line),
        .length_error_seen (length_error_seen)
    );

`ifndef SYNTH
    // The line terminator flag only ever rides on a carriage return
    a_eol_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_line) |-> (char_code == slcan_pkg::CHAR_CR))
        else $error("end_of_line set on a character other than CR");

    // The sticky length error never drops between consecutive results
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) ##1 !empty |-> (length_error_seen || !$past(length_error_seen)))
        else $error("length_error_seen cleared between results");

    // Never pop the job queue while it is empty
    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job queue popped while empty");
`endif

endmodule

### rtl/slcan_front.sv
// Front part of the SLCAN encoder: accepts input items, checks lengths, tracks frame state
// and issues jobs to the queue. Depends on slcan_pkg.
module slcan_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              q_full,
    input  logic              mode,
    input  logic              is_fd,
    input  logic              bit_rate_switch,
    input  logic [1:0]        frame_kind,
    input  logic              extended_id,
    input  logic [28:0]       identifier,
    input  logic [6:0]        byte_count,
    input  logic [7:0]        payload_byte,
    output logic              job_valid,
    output slcan_pkg::job_t   job
);

    logic [6:0] bytes_remaining_reg, bytes_remaining_next;
    logic       discarding_reg, discarding_next;
    logic       length_error_reg, length_error_next;

    logic                  accept;
    slcan_pkg::len_code_t  lc;
    logic [7:0]            letter_base;
    logic [6:0]            remaining_dec;

    assign accept        = push && !q_full;
    assign remaining_dec = bytes_remaining_reg - 7'd1;

    always_comb
    begin
        if (is_fd) begin
            lc = slcan_pkg::fd_len_code(byte_count);
        end else begin
            lc.ok   = (byte_count <= 7'd8);
            lc.code = byte_count[3:0];
        end
        if (byte_count > 7'(MAX_PAYLOAD))
            lc.ok = 1'b0;
    end

    always_comb
    begin
        if (is_fd) begin
            letter_base = bit_rate_switch ? slcan_pkg::CHAR_B_FD_BRS : slcan_pkg::CHAR_D_FD;
        end else begin
            unique case (frame_kind)
                slcan_pkg::FRAME_KIND_DATA:   letter_base = slcan_pkg::CHAR_T_DATA;
                slcan_pkg::FRAME_KIND_REMOTE: letter_base = slcan_pkg::CHAR_R_REMOTE;
                default:                      letter_base = slcan_pkg::CHAR_U_OTHER;
            endcase
        end
    end

    always_comb
    begin
        bytes_remaining_next = bytes_remaining_reg;
        discarding_next      = discarding_reg;
        length_error_next    = length_error_reg;
        job_valid            = 1'b0;

        job.is_header  = (mode == slcan_pkg::MODE_HEADER);
        job.letter     = extended_id ? (letter_base - slcan_pkg::CHAR_CASE_GAP) : letter_base;
        job.ident      = extended_id ? identifier : {18'd0, identifier[10:0]};
        job.num_digits = extended_id ? slcan_pkg::EXT_ID_DIGITS : slcan_pkg::STD_ID_DIGITS;
        job.len_code   = lc.code;
        job.data_byte  = payload_byte;
        job.err_flag   = length_error_reg;
        if (mode == slcan_pkg::MODE_HEADER)
            job.last_idx = job.num_digits + ((byte_count == 7'd0) ? 4'd2 : 4'd1);
        else
            job.last_idx = (bytes_remaining_reg == 7'd1) ? 4'd2 : 4'd1;

        if (accept) begin
            if (mode == slcan_pkg::MODE_HEADER) begin
                bytes_remaining_next = byte_count;
                if (!lc.ok) begin
                    length_error_next = 1'b1;
                    discarding_next   = (byte_count != 7'd0);
                end else begin
                    discarding_next = 1'b0;
                    job_valid       = 1'b1;
                end
            end else if (bytes_remaining_reg != 7'd0) begin
                bytes_remaining_next = remaining_dec;
                if (discarding_reg) begin
                    if (remaining_dec == 7'd0)
                        discarding_next = 1'b0;
                end else begin
                    job_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bytes_remaining_reg <= 7'd0;
            discarding_reg      <= 1'b0;
            length_error_reg    <= 1'b0;
        end else begin
            bytes_remaining_reg <= bytes_remaining_next;
            discarding_reg      <= discarding_next;
            length_error_reg    <= length_error_next;
        end
    end

endmodule

### rtl/slcan_jobq.sv
// Short job queue between the front and back parts of the SLCAN encoder.
// Depends on slcan_pkg for the job type and depth.
module slcan_jobq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  slcan_pkg::job_t  wr_job,
    input  logic             rd_en,
    output slcan_pkg::job_t  rd_job,
    output logic             q_empty,
    output logic             q_full
);

    localparam int DEPTH = slcan_pkg::JOBQ_DEPTH;
    localparam int PTR_W = slcan_pkg::JOBQ_PTR_W;
    localparam int CNT_W = slcan_pkg::JOBQ_CNT_W;

    slcan_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_empty = (count_reg == CNT_W'(0));
    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign rd_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

### rtl/slcan_back.sv
// Back part of the SLCAN encoder: expands queued jobs into characters, one per cycle,
// into a one-entry output register while it is free or popped. Depends on slcan_pkg.
module slcan_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  slcan_pkg::job_t  head_job,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       char_code,
    output logic             end_of_line,
    output logic             length_error_seen
);

    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_eol_reg;
    logic       out_err_reg;

    logic        emit;
    logic        last_char;
    logic [7:0]  ch;
    logic        ch_eol;
    logic [31:0] id_word;
    logic [2:0]  nib_sel;
    logic [3:0]  nib;

    assign emit      = !q_empty && (!out_valid_reg || pop);
    assign last_char = (idx_reg == head_job.last_idx);
    assign q_pop     = emit && last_char;

    assign id_word = {3'b000, head_job.ident};
    assign nib_sel = 3'(head_job.num_digits - idx_reg);
    assign nib     = id_word[{nib_sel, 2'b00} +: 4];

    // Pick the character at the current position of the head job
    always_comb
    begin
        ch_eol = 1'b0;
        if (head_job.is_header) begin
            if (idx_reg == 4'd0) begin
                ch = head_job.letter;
            end else if (idx_reg <= head_job.num_digits) begin
                ch = slcan_pkg::hex_char(nib);
            end else if (idx_reg == head_job.num_digits + 4'd1) begin
                ch = slcan_pkg::hex_char(head_job.len_code);
            end else begin
                ch     = slcan_pkg::CHAR_CR;
                ch_eol = 1'b1;
            end
        end else begin
            if (idx_reg == 4'd0) begin
                ch = slcan_pkg::hex_char(head_job.data_byte[7:4]);
            end else if (idx_reg == 4'd1) begin
                ch = slcan_pkg::hex_char(head_job.data_byte[3:0]);
            end else begin
                ch     = slcan_pkg::CHAR_CR;
                ch_eol = 1'b1;
            end
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (emit) begin
            out_valid_next = 1'b1;
            idx_next       = last_char ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_char_reg <= ch;
            out_eol_reg  <= ch_eol;
            out_err_reg  <= head_job.err_flag;
        end
    end

    assign empty             = !out_valid_reg;
    assign char_code         = out_char_reg;
    assign end_of_line       = out_eol_reg;
    assign length_error_seen = out_err_reg;

endmodule
